@@ hdl/fbc_pkg.sv @@
// Shared constants for the frustum box cull block.
// Depends on nothing; used by every module under hdl.
package fbc_pkg;

  // Default element format: signed Q8.8
  localparam int unsigned ELEMENT_WIDTH_DEF = 16;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  // Packed row width of matrices and registers
  localparam int unsigned ROW_WIDTH = 64;

  // Depth of each queue and credit limit of the stages ahead of it
  localparam int unsigned QUEUE_DEPTH = 8;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_VP_ROW_0 = 2'd0,
    REG_VP_ROW_1 = 2'd1,
    REG_VP_ROW_2 = 2'd2,
    REG_VP_ROW_3 = 2'd3
  } reg_idx_e;

endpackage

@@ hdl/fbc_fifo.sv @@
// Small first-in first-out queue with registered storage.
// Depends on fbc_pkg for the default depth.
module fbc_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = fbc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      count_q, count_d;

  // Store the item at the write pointer
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign empty_o   = (count_q == '0);

  always_comb begin
    count_d = count_q + (AW+1)'(wr_en_i) - (AW+1)'(rd_en_i);
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && !rd_en_i |-> count_q != (AW+1)'(DEPTH))
    else $error("fbc_fifo: write into full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> count_q != '0)
    else $error("fbc_fifo: read from empty queue");
  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_d))
    else $error("fbc_fifo: fill count lost track");
`endif

endmodule

@@ hdl/fbc_front.sv @@
// Front part: accepts boxes and folds the view-projection rows into the world matrix.
// Depends on fbc_pkg; feeds the middle queue through a credit count.
module fbc_front #(
  parameter int unsigned ELEMENT_WIDTH = fbc_pkg::ELEMENT_WIDTH_DEF,
  localparam int unsigned EW = ELEMENT_WIDTH,
  localparam int unsigned TW = 2*EW + 2,
  localparam int unsigned MW = 16*TW + 6*EW
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [15:0]                    box_lo_i [3],
  input  logic [15:0]                    box_hi_i [3],
  input  logic [fbc_pkg::ROW_WIDTH-1:0]  world_row_i [4],
  input  logic [fbc_pkg::ROW_WIDTH-1:0]  vp_row_i [4],
  input  logic                           mid_pop_i,
  output logic                           valid_o,
  output logic [MW-1:0]                  data_o
);

  localparam int unsigned CW = $clog2(fbc_pkg::QUEUE_DEPTH + 1);

  logic                 accept;
  logic [2:0]           valid_q;
  logic [CW-1:0]        cnt_q;
  logic signed [EW-1:0] lo_q [3], hi_q [3], lo2_q [3], hi2_q [3], lo3_q [3], hi3_q [3];
  logic signed [EW-1:0] w_q [4][4];
  logic signed [2*EW-1:0] prod_q [4][4][4];
  logic signed [TW-1:0] t_q [4][4];

  assign full_o = (cnt_q == CW'(fbc_pkg::QUEUE_DEPTH));
  assign accept = push_i && !full_o;

  // Track items in the stages plus those waiting in the middle queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= '0;
    end else begin
      cnt_q   <= cnt_q + CW'(accept) - CW'(mid_pop_i);
      valid_q <= {valid_q[1:0], accept};
    end
  end

  // Stage 1: hold box coordinates and world elements
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      lo_q[k] <= box_lo_i[k][EW-1:0];
      hi_q[k] <= box_hi_i[k][EW-1:0];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        w_q[r][c] <= world_row_i[r][c*EW +: EW];
      end
    end
  end

  // Stage 2: products of view-projection row m element r with world row r
  always_ff @(posedge clk_i) begin
    lo2_q <= lo_q;
    hi2_q <= hi_q;
    for (int m = 0; m < 4; m++) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[m][r][c] <= $signed(vp_row_i[m][r*EW +: EW]) * w_q[r][c];
        end
      end
    end
  end

  // Stage 3: sum products into the combined matrix
  always_ff @(posedge clk_i) begin
    lo3_q <= lo2_q;
    hi3_q <= hi2_q;
    for (int m = 0; m < 4; m++) begin
      for (int c = 0; c < 4; c++) begin
        t_q[m][c] <= TW'(prod_q[m][0][c]) + TW'(prod_q[m][1][c])
                   + TW'(prod_q[m][2][c]) + TW'(prod_q[m][3][c]);
      end
    end
  end

  // Pack for the middle queue
  always_comb begin
    data_o = '0;
    for (int m = 0; m < 4; m++) begin
      for (int c = 0; c < 4; c++) begin
        data_o[(m*4+c)*TW +: TW] = t_q[m][c];
      end
    end
    for (int k = 0; k < 3; k++) begin
      data_o[16*TW + k*EW +: EW]     = lo3_q[k];
      data_o[16*TW + (3+k)*EW +: EW] = hi3_q[k];
    end
  end

  assign valid_o = valid_q[2];

endmodule

@@ hdl/fbc_back.sv @@
// Back part: forms the six planes, tests the box extremes against each and decides visibility.
// Depends on fbc_pkg; drains the middle queue and feeds the result queue by credit.
module fbc_back #(
  parameter int unsigned ELEMENT_WIDTH = fbc_pkg::ELEMENT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = fbc_pkg::FRACTION_BITS_DEF,
  localparam int unsigned EW = ELEMENT_WIDTH,
  localparam int unsigned TW = 2*EW + 2,
  localparam int unsigned MW = 16*TW + 6*EW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mid_empty_i,
  input  logic [MW-1:0] mid_data_i,
  output logic          mid_pop_o,
  input  logic          out_pop_i,
  output logic          out_push_o,
  output logic          out_visible_o
);

  localparam int unsigned CW = $clog2(fbc_pkg::QUEUE_DEPTH + 1);
  localparam int unsigned QW = TW + 1;
  localparam int unsigned PW = QW + EW;
  localparam int unsigned DW = PW + 3;

  logic [CW-1:0]        cnt_q;
  logic [1:0]           valid_q;
  logic signed [TW-1:0] t [4][4];
  logic signed [QW-1:0] q_q [6][4];
  logic signed [EW-1:0] lo_q [3], hi_q [3];
  logic signed [PW-1:0] pl_q [6][3], ph_q [6][3];
  logic signed [DW-1:0] c3_q [6];
  logic signed [DW-1:0] dmax;
  logic                 vis;

  assign mid_pop_o = !mid_empty_i && (cnt_q != CW'(fbc_pkg::QUEUE_DEPTH));

  // Count items in the back stages plus those waiting in the result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= '0;
    end else begin
      cnt_q   <= cnt_q + CW'(mid_pop_o) - CW'(out_pop_i);
      valid_q <= {valid_q[0], mid_pop_o};
    end
  end

  // Unpack the combined matrix
  always_comb begin
    for (int m = 0; m < 4; m++) begin
      for (int c = 0; c < 4; c++) begin
        t[m][c] = $signed(mid_data_i[(m*4+c)*TW +: TW]);
      end
    end
  end

  // Stage 1: planes in box space, row 3 plus and minus rows 0 to 2
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      lo_q[k] <= $signed(mid_data_i[16*TW + k*EW +: EW]);
      hi_q[k] <= $signed(mid_data_i[16*TW + (3+k)*EW +: EW]);
      for (int c = 0; c < 4; c++) begin
        q_q[2*k][c]   <= QW'(t[3][c]) + QW'(t[k][c]);
        q_q[2*k+1][c] <= QW'(t[3][c]) - QW'(t[k][c]);
      end
    end
  end

  // Stage 2: plane terms at both ends of each axis
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      for (int c = 0; c < 3; c++) begin
        pl_q[k][c] <= q_q[k][c] * lo_q[c];
        ph_q[k][c] <= q_q[k][c] * hi_q[c];
      end
      c3_q[k] <= DW'(q_q[k][3]) <<< FRACTION_BITS;
    end
  end

  // Stage 3: take the best corner per plane; drop the box if any plane rejects it
  always_comb begin
    vis  = 1'b1;
    dmax = '0;
    for (int k = 0; k < 6; k++) begin
      dmax = c3_q[k];
      for (int c = 0; c < 3; c++) begin
        dmax = dmax + ((pl_q[k][c] > ph_q[k][c]) ? DW'(pl_q[k][c]) : DW'(ph_q[k][c]));
      end
      if (dmax <= 0) begin
        vis = 1'b0;
      end
    end
  end

  assign out_push_o    = valid_q[1];
  assign out_visible_o = vis;

endmodule

@@ hdl/frustum_box_cull.sv @@
// Frustum culling of one world-transformed box per item against six planes.
// Throughput: one item per cycle while neither side stalls, set by the fully pipelined
// front and back multipliers. Each side stalls on its own; the middle and result queues
// hold eight items each. Reset clears the view-projection registers to zero and empties
// both queues.
module frustum_box_cull #(
  parameter int unsigned ELEMENT_WIDTH = fbc_pkg::ELEMENT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = fbc_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [fbc_pkg::ROW_WIDTH-1:0] cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [15:0]            box_min_x_i,
  input  logic signed [15:0]            box_min_y_i,
  input  logic signed [15:0]            box_min_z_i,
  input  logic signed [15:0]            box_max_x_i,
  input  logic signed [15:0]            box_max_y_i,
  input  logic signed [15:0]            box_max_z_i,
  input  logic [fbc_pkg::ROW_WIDTH-1:0] world_row_0_i,
  input  logic [fbc_pkg::ROW_WIDTH-1:0] world_row_1_i,
  input  logic [fbc_pkg::ROW_WIDTH-1:0] world_row_2_i,
  input  logic [fbc_pkg::ROW_WIDTH-1:0] world_row_3_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          visible_o
);

  localparam int unsigned EW = ELEMENT_WIDTH;
  localparam int unsigned TW = 2*EW + 2;
  localparam int unsigned MW = 16*TW + 6*EW;

  logic [fbc_pkg::ROW_WIDTH-1:0] vp_q [4];
  logic [fbc_pkg::ROW_WIDTH-1:0] world [4];
  logic [15:0]                   lo [3], hi [3];
  logic                          mid_push, mid_pop, mid_empty;
  logic [MW-1:0]                 mid_wdata, mid_rdata;
  logic                          out_push, out_vis, out_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        vp_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (fbc_pkg::reg_idx_e'(cfg_idx_i))
        fbc_pkg::REG_VP_ROW_0: vp_q[0] <= cfg_wdata_i;
        fbc_pkg::REG_VP_ROW_1: vp_q[1] <= cfg_wdata_i;
        fbc_pkg::REG_VP_ROW_2: vp_q[2] <= cfg_wdata_i;
        fbc_pkg::REG_VP_ROW_3: vp_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign lo    = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign hi    = '{box_max_x_i, box_max_y_i, box_max_z_i};
  assign world = '{world_row_0_i, world_row_1_i, world_row_2_i, world_row_3_i};

  fbc_front #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .push_i     (push),
    .full_o     (full),
    .box_lo_i   (lo),
    .box_hi_i   (hi),
    .world_row_i(world),
    .vp_row_i   (vp_q),
    .mid_pop_i  (mid_pop),
    .valid_o    (mid_push),
    .data_o     (mid_wdata)
  );

  fbc_fifo #(.WIDTH(MW)) u_mid_q (
    .clk_i, .rst_ni,
    .wr_en_i  (mid_push),
    .wr_data_i(mid_wdata),
    .rd_en_i  (mid_pop),
    .rd_data_o(mid_rdata),
    .empty_o  (mid_empty)
  );

  fbc_back #(.ELEMENT_WIDTH(ELEMENT_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni,
    .mid_empty_i  (mid_empty),
    .mid_data_i   (mid_rdata),
    .mid_pop_o    (mid_pop),
    .out_pop_i    (out_pop),
    .out_push_o   (out_push),
    .out_visible_o(out_vis)
  );

  assign out_pop = pop && !empty;

  fbc_fifo #(.WIDTH(1)) u_out_q (
    .clk_i, .rst_ni,
    .wr_en_i  (out_push),
    .wr_data_i(out_vis),
    .rd_en_i  (out_pop),
    .rd_data_o(visible_o),
    .empty_o  (empty)
  );

endmodule

@@ test/fbc_checker.sv @@
// Checker for the frustum box cull block: watches the push and pop channels,
// predicts the visibility flag of each accepted box and compares it in order.
// Depends on fbc_pkg for the row width.
`timescale 1ns / 1ps
module fbc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [fbc_pkg::ROW_WIDTH-1:0] cfg_wdata_i,
  input  logic                          push,
  input  logic                          full,
  input  logic signed [15:0]            box_min_x_i,
  input  logic signed [15:0]            box_min_y_i,
  input  logic signed [15:0]            box_min_z_i,
  input  logic signed [15:0]            box_max_x_i,
  input  logic signed [15:0]            box_max_y_i,
  input  logic signed [15:0]            box_max_z_i,
  input  logic [fbc_pkg::ROW_WIDTH-1:0] world_row_0_i,
  input  logic [fbc_pkg::ROW_WIDTH-1:0] world_row_1_i,
  input  logic [fbc_pkg::ROW_WIDTH-1:0] world_row_2_i,
  input  logic [fbc_pkg::ROW_WIDTH-1:0] world_row_3_i,
  input  logic                          empty,
  input  logic                          pop,
  input  logic                          visible_o,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            culled_count_o,
  output int                            seen_count_o
);
  import fbc_pkg::*;

  logic [ROW_WIDTH-1:0] vp_row [4];
  bit                   visible_q [$];

  // Signed Q8.8 element i of a packed row
  function automatic longint row_elem(logic [ROW_WIDTH-1:0] row, int i);
    logic signed [15:0] e;
    e = row[i*16 +: 16];
    return longint'(e);
  endfunction

  // Visibility of a box transformed by the world rows against the six planes
  function automatic bit box_visible(longint lo[3], longint hi[3],
                                     logic [ROW_WIDTH-1:0] wr[4]);
    longint pl[6][4];
    longint pt[8][4];
    longint v[4];
    longint acc;
    bit     any;
    for (int k = 0; k < 3; k++)
      for (int c = 0; c < 4; c++) begin
        pl[2*k][c]   = row_elem(vp_row[3], c) + row_elem(vp_row[k], c);
        pl[2*k+1][c] = row_elem(vp_row[3], c) - row_elem(vp_row[k], c);
      end
    for (int j = 0; j < 8; j++) begin
      v[0] = j[0] ? hi[0] : lo[0];
      v[1] = j[1] ? hi[1] : lo[1];
      v[2] = j[2] ? hi[2] : lo[2];
      v[3] = 256;
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int c = 0; c < 4; c++) acc += row_elem(wr[r], c) * v[c];
        pt[j][r] = acc;
      end
    end
    for (int k = 0; k < 6; k++) begin
      any = 0;
      for (int j = 0; j < 8; j++) begin
        acc = 0;
        for (int c = 0; c < 4; c++) acc += pl[k][c] * pt[j][c];
        if (acc > 0) any = 1;
      end
      if (!any) return 0;
    end
    return 1;
  endfunction

  assign pending_o = visible_q.size();

  // Track registers, predict on push, compare on pop
  always @(posedge clk_i or negedge rst_ni) begin
    longint               lo[3], hi[3];
    logic [ROW_WIDTH-1:0] wr[4];
    bit                   exp_vis;
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) vp_row[k] <= '0;
      visible_q.delete();
      fail_count_o   <= 0;
      culled_count_o <= 0;
      seen_count_o   <= 0;
    end else begin
      if (cfg_we_i) vp_row[cfg_idx_i] <= cfg_wdata_i;
      if (push && !full) begin
        lo[0] = box_min_x_i; lo[1] = box_min_y_i; lo[2] = box_min_z_i;
        hi[0] = box_max_x_i; hi[1] = box_max_y_i; hi[2] = box_max_z_i;
        wr[0] = world_row_0_i; wr[1] = world_row_1_i;
        wr[2] = world_row_2_i; wr[3] = world_row_3_i;
        visible_q.push_back(box_visible(lo, hi, wr));
      end
      if (pop && !empty) begin
        seen_count_o <= seen_count_o + 1;
        if (!visible_o) culled_count_o <= culled_count_o + 1;
        if (visible_q.size() == 0) begin
          $error("visible: result with no item waiting, actual %0b", visible_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_vis = visible_q.pop_front();
          if (exp_vis !== visible_o) begin
            $error("visible: expected %0b, actual %0b", exp_vis, visible_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ test/tb.sv @@
// Top of the frustum box cull testbench: drives boxes, register writes and
// pop stalls, and gives the verdict. Depends on fbc_pkg and fbc_checker.
`timescale 1ns / 1ps
module tb;
  import fbc_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RAND_ITEMS  = 650;
  localparam int DRAIN_WAIT  = 20;

  logic                 clk_i, rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_idx_i;
  logic [ROW_WIDTH-1:0] cfg_wdata_i;
  logic                 push, full, empty, pop, visible_o;
  logic signed [15:0]   bmin [3];
  logic signed [15:0]   bmax [3];
  logic [ROW_WIDTH-1:0] wrow [4];
  int                   fail_count, pending, culled_count, seen_count;
  int                   idle_cycles;
  bit                   stall_on;

  frustum_box_cull u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .push, .full,
    .box_min_x_i(bmin[0]), .box_min_y_i(bmin[1]), .box_min_z_i(bmin[2]),
    .box_max_x_i(bmax[0]), .box_max_y_i(bmax[1]), .box_max_z_i(bmax[2]),
    .world_row_0_i(wrow[0]), .world_row_1_i(wrow[1]),
    .world_row_2_i(wrow[2]), .world_row_3_i(wrow[3]),
    .empty, .pop, .visible_o
  );

  fbc_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .push, .full,
    .box_min_x_i(bmin[0]), .box_min_y_i(bmin[1]), .box_min_z_i(bmin[2]),
    .box_max_x_i(bmax[0]), .box_max_y_i(bmax[1]), .box_max_z_i(bmax[2]),
    .world_row_0_i(wrow[0]), .world_row_1_i(wrow[1]),
    .world_row_2_i(wrow[2]), .world_row_3_i(wrow[3]),
    .empty, .pop, .visible_o,
    .fail_count_o(fail_count), .pending_o(pending),
    .culled_count_o(culled_count), .seen_count_o(seen_count)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Pack four Q8.8 elements into a row
  function automatic logic [ROW_WIDTH-1:0] pack(int e0, int e1, int e2, int e3);
    return {e3[15:0], e2[15:0], e1[15:0], e0[15:0]};
  endfunction

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [ROW_WIDTH-1:0] rand_row();
    return {rand_elem(), rand_elem(), rand_elem(), rand_elem()};
  endfunction

  // Write one register at a clock edge
  task automatic write_reg(reg_idx_e idx, logic [ROW_WIDTH-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic write_all(logic [ROW_WIDTH-1:0] r0, r1, r2, r3);
    write_reg(REG_VP_ROW_0, r0);
    write_reg(REG_VP_ROW_1, r1);
    write_reg(REG_VP_ROW_2, r2);
    write_reg(REG_VP_ROW_3, r3);
  endtask

  // Hold one box on the port until accepted, with optional idle burst first
  task automatic send_box(logic [15:0] mn[3], logic [15:0] mx[3],
                          logic [ROW_WIDTH-1:0] wr[4], bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    push <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      bmin[k] <= mn[k];
      bmax[k] <= mx[k];
    end
    for (int r = 0; r < 4; r++) wrow[r] <= wr[r];
    do @(posedge clk_i); while (full);
  endtask

  // Stop pushing, let the checker log the last accepted item, then empty out
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Random box: mostly near a small cube, sometimes full-range noise
  task automatic rand_box(bit gaps);
    logic [15:0]          mn[3], mx[3];
    logic [ROW_WIDTH-1:0] wr[4];
    int                   c, h;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        mn[k] = 16'($urandom);
        mx[k] = 16'($urandom);
      end else begin
        c = int'($urandom_range(0, 2048)) - 1024;
        h = $urandom_range(0, 256);
        mn[k] = 16'(c - h);
        mx[k] = 16'(c + h);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      for (int r = 0; r < 4; r++) wr[r] = rand_row();
    end else begin
      wr[0] = pack(256, 0, 0, int'($urandom_range(0, 1024)) - 512);
      wr[1] = pack(0, 256, 0, int'($urandom_range(0, 1024)) - 512);
      wr[2] = pack(0, 0, 256, int'($urandom_range(0, 1024)) - 512);
      wr[3] = pack(0, 0, 0, 256);
    end
    send_box(mn, mx, wr, gaps);
  endtask

  // Pop side: random stall bursts until the last phase
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted item on either side and no register write
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0]          mn[3], mx[3];
    logic [ROW_WIDTH-1:0] id[4];
    push = 0; cfg_we_i = 0; cfg_idx_i = '0; cfg_wdata_i = '0;
    for (int k = 0; k < 3; k++) begin bmin[k] = '0; bmax[k] = '0; end
    for (int r = 0; r < 4; r++) wrow[r] = '0;
    stall_on = 1;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: all-zero registers give degenerate planes, so boxes are culled
    id[0] = pack(256, 0, 0, 0); id[1] = pack(0, 256, 0, 0);
    id[2] = pack(0, 0, 256, 0); id[3] = pack(0, 0, 0, 256);
    mn = '{16'hff00, 16'hff00, 16'hff00}; mx = '{16'h0100, 16'h0100, 16'h0100};
    send_box(mn, mx, id, 0);
    drain();

    // Identity view-projection: unit cube clip space
    write_all(pack(256, 0, 0, 0), pack(0, 256, 0, 0),
              pack(0, 0, 256, 0), pack(0, 0, 0, 256));
    send_box(mn, mx, id, 0);
    mn = '{16'h0400, 16'h0000, 16'h0000}; mx = '{16'h0500, 16'h0080, 16'h0080};
    send_box(mn, mx, id, 0);
    // Min above max, and field extremes
    mn = '{16'h0080, 16'h0080, 16'h0080}; mx = '{16'hff80, 16'hff80, 16'hff80};
    send_box(mn, mx, id, 0);
    mn = '{16'h8000, 16'h8000, 16'h8000}; mx = '{16'h7fff, 16'h7fff, 16'h7fff};
    send_box(mn, mx, id, 0);
    // Box touching a plane exactly: dot zero counts as outside
    mn = '{16'h0100, 16'h0000, 16'h0000}; mx = '{16'h0200, 16'h0000, 16'h0000};
    send_box(mn, mx, id, 0);
    // Extreme world matrices
    for (int r = 0; r < 4; r++) id[r] = {4{16'h8000}};
    send_box(mn, mx, id, 0);
    for (int r = 0; r < 4; r++) id[r] = {4{16'h7fff}};
    send_box(mn, mx, id, 0);
    for (int r = 0; r < 4; r++) id[r] = {64{1'b1}};
    send_box(mn, mx, id, 0);
    drain();

    // Extreme registers
    write_all({4{16'h8000}}, {4{16'h7fff}}, {4{16'h8000}}, {4{16'h7fff}});
    repeat (10) rand_box(0);
    drain();
    write_all({64{1'b1}}, '0, {4{16'h7fff}}, {4{16'h8000}});
    repeat (10) rand_box(0);
    drain();

    // Random phases under several register settings
    for (int p = 0; p < 5; p++) begin
      if (p == 4) stall_on = 0;
      if (p == 0)
        write_all(pack(256, 0, 0, 0), pack(0, 256, 0, 0),
                  pack(0, 0, 256, 0), pack(0, 0, 0, 256));
      else if (p == 1)
        write_all(pack(128, 0, 0, 0), pack(0, 128, 0, 0),
                  pack(0, 0, -256, -512), pack(0, 0, -256, 0));
      else
        write_all(rand_row(), rand_row(), rand_row(), rand_row());
      repeat (RAND_ITEMS / 5) rand_box(p != 4);
      drain();
    end

    $display("Covered %0d boxes, %0d culled, across identity, perspective,",
             seen_count, culled_count);
    $display("extreme and random view-projection settings.");
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
